>>> rtl/core/thrh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thrh_pkg
// Shared sizes, codes and types of the token time/rate histogram unit.
// ----------------------------------------------------------------------------
package thrh_pkg;

    localparam int ROWS        = 96;
    localparam int COLS        = 9;
    localparam int COUNT_WIDTH = 20;

    localparam int TOK_DEPTH = 7;
    localparam int LEN_W     = 3;
    localparam int CELLS     = ROWS * COLS;
    localparam int ADDR_W    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int ROW_W     = 9;
    localparam int COL_W     = 4;
    localparam int PROD_W    = ROW_W + COL_W;
    localparam int OUT_W     = 20;

    localparam logic MODE_READ = 1'b1;

    typedef logic [ADDR_W-1:0]      t_addr;
    typedef logic [COUNT_WIDTH-1:0] t_count;

    typedef struct packed {
        logic  inc;
        logic  rd;
        logic  oor;
        logic  halt;
        t_addr addr;
    } t_req;

endpackage

>>> rtl/core/token_time_rate_histogram_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// token_time_rate_histogram_unit
// Parses a byte stream into time/rate tokens and counts them in a
// quarter-hour by rate-bin histogram held in one synchronous memory.
// ----------------------------------------------------------------------------
// One item is taken every cycle while the input is not stalled. A text byte
// finishes in the cycle it is taken; a byte ending a countable token issues
// one read-modify-write of the count memory (read in the accept cycle, write
// in the next, with the last write forwarded so back-to-back hits on one
// cell count correctly). A read passes the request and result registers.
// Input stalls only while a read result waits behind a full, stalled result
// register, or while after reset the count memory is cleared, one cell a
// cycle through its single write port: ROWS*COLS cells, 864 by default.
module token_time_rate_histogram_unit import thrh_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic             i_mode,
    input  logic [7:0]       i_char_byte,
    input  logic [6:0]       i_read_row,
    input  logic [3:0]       i_read_col,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [OUT_W-1:0] o_bin_count,
    output logic             o_halted
);

    t_req req;
    logic accept, busy, block;

    assign o_stall = busy || block;
    assign accept  = i_valid && !o_stall;

    thrh_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_mode      (i_mode),
        .i_char_byte (i_char_byte),
        .i_read_row  (i_read_row),
        .i_read_col  (i_read_col),
        .o_req       (req)
    );

    thrh_update u_update (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .i_out_stall (i_stall),
        .o_busy      (busy),
        .o_block     (block),
        .o_valid     (o_valid),
        .o_bin_count (o_bin_count),
        .o_halted    (o_halted)
    );

endmodule

>>> rtl/core/thrh_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thrh_parser
// Token buffer, rate binning, time to row conversion and halt state; turns
// each accepted item into a count or read request for the count memory.
// ----------------------------------------------------------------------------
module thrh_parser import thrh_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic       i_mode,
    input  logic [7:0] i_char_byte,
    input  logic [6:0] i_read_row,
    input  logic [3:0] i_read_col,
    output t_req       o_req
);

    function automatic logic is_delim(input logic [7:0] b);
        return (b >= 8'd9 && b <= 8'd13) || (b >= 8'd32 && b <= 8'd47) ||
               (b >= 8'd58 && b <= 8'd64) || (b >= 8'd91 && b <= 8'd96) ||
               (b >= 8'd123 && b <= 8'd126);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'd48 && b <= 8'd57;
    endfunction

    logic [7:0]       r_chars [TOK_DEPTH];
    logic [LEN_W-1:0] r_len;
    logic             r_in_token;
    logic             r_halt;

    logic [TOK_DEPTH-1:0] dig;
    logic [3:0]           val [TOK_DEPTH];
    logic                 r4, r5, r6;
    logic                 in_bin, rate_ok, time_ok, row_ok, rd_ok;
    logic [COL_W-1:0]     col;
    logic [6:0]           hh, mm;
    logic [2:0]           q;
    logic [ROW_W-1:0]     row;
    logic [PROD_W-1:0]    inc_full, rd_full;
    logic                 delim, text_go, finish, rd_go;

    always_comb begin
        for (int i = 0; i < TOK_DEPTH; i++) begin
            dig[i] = is_digit(r_chars[i]) && (r_len > LEN_W'(i));
            val[i] = 4'(r_chars[i] - 8'd48);
        end
    end

    // leading digits among characters 4 to 6
    assign r4 = dig[4];
    assign r5 = r4 && dig[5];
    assign r6 = r5 && dig[6];

    always_comb begin
        in_bin = 1'b0;
        col    = '0;
        if (r5 && !r6 && val[4] >= 4'd4) begin
            in_bin = 1'b1;
            col    = val[4] - 4'd4;
        end else if (r6 && val[4] == 4'd1 && val[5] <= 4'd2) begin
            in_bin = 1'b1;
            col    = val[5] + 4'd6;
        end else if (r6 && val[4] == 4'd0 && val[5] >= 4'd4) begin
            in_bin = 1'b1;
            col    = val[5] - 4'd4;
        end
    end

    assign rate_ok = in_bin && (col < COL_W'(COLS));
    assign time_ok = (r_len >= LEN_W'(4)) && (&dig[3:0]);

    assign hh = 7'(val[0]) * 7'd10 + 7'(val[1]);
    assign mm = 7'(val[2]) * 7'd10 + 7'(val[3]);
    assign q  = 3'(mm >= 7'd15) + 3'(mm >= 7'd30) + 3'(mm >= 7'd45) +
                3'(mm >= 7'd60) + 3'(mm >= 7'd75) + 3'(mm >= 7'd90);
    assign row    = ROW_W'({hh, 2'b00}) + ROW_W'(q);
    assign row_ok = row < ROW_W'(ROWS);

    assign inc_full = PROD_W'(row) * PROD_W'(COLS) + PROD_W'(col);
    assign rd_full  = PROD_W'(i_read_row) * PROD_W'(COLS) + PROD_W'(i_read_col);
    assign rd_ok    = (ROW_W'(i_read_row) < ROW_W'(ROWS)) && (i_read_col < COL_W'(COLS));

    assign delim   = is_delim(i_char_byte);
    assign rd_go   = i_accept && (i_mode == MODE_READ);
    assign text_go = i_accept && (i_mode != MODE_READ) && !r_halt;
    assign finish  = text_go && delim && r_in_token;

    always_comb begin
        o_req.inc  = finish && rate_ok && time_ok && row_ok;
        o_req.rd   = rd_go;
        o_req.oor  = !rd_ok;
        o_req.halt = r_halt;
        o_req.addr = rd_go ? rd_full[ADDR_W-1:0] : inc_full[ADDR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TOK_DEPTH; i++) r_chars[i] <= '0;
            r_len      <= '0;
            r_in_token <= 1'b0;
            r_halt     <= 1'b0;
        end else if (finish) begin
            for (int i = 0; i < TOK_DEPTH; i++) r_chars[i] <= '0;
            r_len      <= '0;
            r_in_token <= 1'b0;
            r_halt     <= !rate_ok;
        end else if (text_go && !delim) begin
            r_in_token <= 1'b1;
            if (r_len < LEN_W'(TOK_DEPTH)) begin
                r_chars[r_len] <= i_char_byte;
                r_len          <= r_len + LEN_W'(1);
            end
        end
    end

endmodule

>>> rtl/core/thrh_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thrh_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module thrh_ram #(
    parameter int W     = 20,
    parameter int DEPTH = 864,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) mem[i_waddr] <= i_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (i_re) r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/thrh_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thrh_update
// Count memory with clearing pass, read-modify-write increment with
// forwarding of the last write, and the result register.
// ----------------------------------------------------------------------------
module thrh_update import thrh_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_req             i_req,
    input  logic             i_out_stall,
    output logic             o_busy,
    output logic             o_block,
    output logic             o_valid,
    output logic [OUT_W-1:0] o_bin_count,
    output logic             o_halted
);

    logic             r_clr_busy;
    t_addr            r_clr_addr;
    logic             r_s1_valid, r_s1_inc, r_s1_rd, r_s1_oor, r_s1_halt;
    t_addr            r_s1_addr;
    logic             r_last_valid;
    t_addr            r_last_addr;
    t_count           r_last_data;
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_count;
    logic             r_out_halted;

    t_count rdata, cur, n_wdata;
    logic   re, we, out_free, s1_adv;
    t_addr  waddr;
    t_count wdata;

    assign out_free = !r_out_valid || !i_out_stall;
    assign s1_adv   = !(r_s1_valid && r_s1_rd) || out_free;
    assign re       = i_req.inc || i_req.rd;

    assign cur     = (r_last_valid && r_last_addr == r_s1_addr) ? r_last_data : rdata;
    assign n_wdata = (&cur) ? cur : cur + COUNT_WIDTH'(1);

    assign we    = r_clr_busy || (r_s1_valid && r_s1_inc);
    assign waddr = r_clr_busy ? r_clr_addr : r_s1_addr;
    assign wdata = r_clr_busy ? '0 : n_wdata;

    thrh_ram #(
        .W     (COUNT_WIDTH),
        .DEPTH (CELLS),
        .AW    (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (i_req.addr),
        .o_rdata (rdata)
    );

    // clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == ADDR_W'(CELLS - 1)) r_clr_busy <= 1'b0;
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_last_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_s1_valid   <= re;
                r_last_valid <= r_s1_valid && r_s1_inc;
            end
            if (out_free) r_out_valid <= r_s1_valid && r_s1_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s1_inc    <= i_req.inc;
            r_s1_rd     <= i_req.rd;
            r_s1_oor    <= i_req.oor;
            r_s1_halt   <= i_req.halt;
            r_s1_addr   <= i_req.addr;
            r_last_addr <= r_s1_addr;
            r_last_data <= n_wdata;
        end
        if (out_free) begin
            r_out_count  <= r_s1_oor ? '0 : OUT_W'(cur);
            r_out_halted <= r_s1_halt;
        end
    end

    assign o_busy      = r_clr_busy;
    assign o_block     = r_s1_valid && r_s1_rd && !out_free;
    assign o_valid     = r_out_valid;
    assign o_bin_count = r_out_count;
    assign o_halted    = r_out_halted;

endmodule

>>> rtl/core/thrh_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thrh_checker
// Port-level checks of the histogram unit, bound to the top level.
// ----------------------------------------------------------------------------
module thrh_checker import thrh_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_stall,
    input logic             i_mode,
    input logic [7:0]       i_char_byte,
    input logic [6:0]       i_read_row,
    input logic [3:0]       i_read_col,
    input logic             o_valid,
    input logic             i_stall,
    input logic [OUT_W-1:0] o_bin_count,
    input logic             o_halted
);

    logic r_seen_halt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_halt <= 1'b0;
        end else if (o_valid && !i_stall && o_halted) begin
            r_seen_halt <= 1'b1;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_bin_count) && $stable(o_halted))
        else $error("stalled result changed");

    a_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> o_stall && !o_valid)
        else $error("input not stalled during clearing pass");

    a_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_seen_halt |-> o_halted)
        else $error("halt flag dropped");

    a_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && !o_stall && i_mode == MODE_READ, 2))
        else $error("result without read item");

endmodule

bind token_time_rate_histogram_unit thrh_checker u_chk (.*);

>>> tb/sv/tb_token_time_rate_histogram_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_token_time_rate_histogram_unit
// Self-checking bench for the token time/rate histogram unit. A queue-fed
// driver streams text bytes and cell reads, an in-bench histogram predicts
// every read, and a monitor compares each returned item against the oldest
// prediction. The run steps through idle and stall mixes, one long output
// hold-off, and ends by halting the counter with an out-of-range rate.
// ----------------------------------------------------------------------------
module tb_token_time_rate_histogram_unit;
    import thrh_pkg::*;

    localparam logic MODE_TEXT      = 1'b0;
    localparam int   WATCHDOG_LIMIT = 4000;
    localparam int   LONG_HOLD      = 300;
    localparam int   PHASE_ITEMS    = 380;

    typedef struct packed {
        logic       mode;
        logic [7:0] chr;
        logic [6:0] row;
        logic [3:0] col;
    } t_item;

    typedef struct packed {
        logic [OUT_W-1:0] count;
        logic             halted;
    } t_readout;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_valid     = 1'b0;
    logic             i_mode      = 1'b0;
    logic [7:0]       i_char_byte = '0;
    logic [6:0]       i_read_row  = '0;
    logic [3:0]       i_read_col  = '0;
    logic             i_stall     = 1'b0;
    logic             o_stall;
    logic             o_valid;
    logic [OUT_W-1:0] o_bin_count;
    logic             o_halted;

    t_item    pending_items[$];
    t_readout expected_reads[$];

    logic [7:0]  tok_chars [TOK_DEPTH];
    int unsigned tok_len;
    logic        tok_open;
    logic        halt_seen;
    t_count      hist [CELLS];

    int   send_idle_pct  = 0;
    int   stall_pct      = 0;
    logic hold_req       = 1'b0;
    logic hold_done      = 1'b0;
    int   hold_left      = 0;
    int   mismatches     = 0;
    int   idle_cycles    = 0;
    int   queued         = 0;
    int   tokens_counted = 0;
    int   tokens_dropped = 0;
    int   reads_checked  = 0;
    int   last_hh        = 12;
    int   last_mm        = 0;
    int   last_rate      = 75;

    always #5 i_clk = ~i_clk;

    token_time_rate_histogram_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_mode      (i_mode),
        .i_char_byte (i_char_byte),
        .i_read_row  (i_read_row),
        .i_read_col  (i_read_col),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_bin_count (o_bin_count),
        .o_halted    (o_halted)
    );

    function automatic bit is_sep(logic [7:0] b);
        return (b >= 9 && b <= 13) || (b >= 32 && b <= 47) || (b >= 58 && b <= 64) ||
               (b >= 91 && b <= 96) || (b >= 123 && b <= 126);
    endfunction

    function automatic bit is_num(logic [7:0] b);
        return b >= 48 && b <= 57;
    endfunction

    function automatic void clear_token();
        foreach (tok_chars[i]) tok_chars[i] = '0;
        tok_len  = 0;
        tok_open = 1'b0;
    endfunction

    function automatic void close_token();
        int unsigned rate;
        int unsigned col_idx;
        int unsigned minutes;
        int unsigned row_idx;
        bit          stop;
        bit          time_ok;
        rate = 0;
        stop = 1'b0;
        for (int i = 4; i < TOK_DEPTH; i++) begin
            if (!stop && i < tok_len) begin
                if (is_num(tok_chars[i])) rate = rate * 10 + (tok_chars[i] - 48);
                else stop = 1'b1;
            end
        end
        if (rate < 40 || rate >= 130 || (rate - 40) / 10 >= COLS) begin
            halt_seen = 1'b1;
            return;
        end
        col_idx = (rate - 40) / 10;
        time_ok = tok_len >= 4;
        for (int i = 0; i < 4; i++)
            if (!is_num(tok_chars[i])) time_ok = 1'b0;
        if (!time_ok) begin
            tokens_dropped++;
            return;
        end
        minutes = ((tok_chars[0] - 48) * 10 + (tok_chars[1] - 48)) * 60 +
                  (tok_chars[2] - 48) * 10 + (tok_chars[3] - 48);
        row_idx = minutes / 15;
        if (row_idx >= ROWS) begin
            tokens_dropped++;
            return;
        end
        if (hist[row_idx * COLS + col_idx] != '1)
            hist[row_idx * COLS + col_idx] = hist[row_idx * COLS + col_idx] + 1'b1;
        tokens_counted++;
    endfunction

    function automatic void histogram_apply(t_item it);
        t_readout r;
        if (it.mode == MODE_READ) begin
            r.count = '0;
            if (it.row < ROWS && it.col < COLS)
                r.count = hist[it.row * COLS + it.col][OUT_W-1:0];
            r.halted = halt_seen;
            expected_reads.push_back(r);
            return;
        end
        if (halt_seen) return;
        if (is_sep(it.chr)) begin
            if (tok_open) begin
                close_token();
                clear_token();
            end
        end else begin
            tok_open = 1'b1;
            if (tok_len < TOK_DEPTH) begin
                tok_chars[tok_len] = it.chr;
                tok_len++;
            end
        end
    endfunction

    function automatic logic [7:0] any_sep();
        case ($urandom_range(0, 4))
            0: return 8'($urandom_range(9, 13));
            1: return 8'($urandom_range(32, 47));
            2: return 8'($urandom_range(58, 64));
            3: return 8'($urandom_range(91, 96));
            default: return 8'($urandom_range(123, 126));
        endcase
    endfunction

    function automatic logic [7:0] any_char();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (is_sep(b));
        return b;
    endfunction

    task automatic push_char(int b);
        pending_items.push_back('{MODE_TEXT, 8'(b), 7'($urandom_range(0, 127)),
                                  4'($urandom_range(0, 15))});
        queued++;
    endtask

    task automatic push_read(int r, int c);
        pending_items.push_back('{MODE_READ, 8'($urandom_range(0, 255)), 7'(r), 4'(c)});
        queued++;
    endtask

    task automatic push_token(int hh, int mm, int rate, bit lead_zero, int tail);
        logic [7:0] b;
        push_char(48 + hh / 10);
        push_char(48 + hh % 10);
        push_char(48 + mm / 10);
        push_char(48 + mm % 10);
        if (rate >= 100 || lead_zero) push_char(48 + (rate / 100) % 10);
        push_char(48 + (rate / 10) % 10);
        push_char(48 + rate % 10);
        for (int i = 0; i < tail; i++) begin
            b = any_char();
            if (i == 0 && rate < 100 && !lead_zero)
                while (is_num(b)) b = any_char();
            push_char(b);
        end
        push_char(any_sep());
    endtask

    task automatic push_broken_token();
        int rate;
        rate = $urandom_range(40, 99);
        for (int i = 0; i < 4; i++)
            push_char($urandom_range(0, 1) ? 48 + $urandom_range(0, 9) : int'(any_char()));
        push_char(48 + rate / 10);
        push_char(48 + rate % 10);
        push_char(any_sep());
    endtask

    task automatic push_random_group();
        int sel;
        int pick;
        sel = $urandom_range(0, 99);
        if (sel < 55) begin
            if ($urandom_range(0, 2) != 0) begin
                last_hh   = $urandom_range(0, 23);
                last_mm   = $urandom_range(0, 59);
                last_rate = $urandom_range(40, 129);
            end
            push_token(last_hh, last_mm, last_rate,
                       last_rate < 100 && $urandom_range(0, 4) == 0,
                       $urandom_range(0, 3) == 0 ? $urandom_range(1, 4) : 0);
            if ($urandom_range(0, 5) == 0) push_char(any_sep());
        end else if (sel < 80) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                push_read((last_hh * 60 + last_mm) / 15, (last_rate - 40) / 10);
            else if (pick < 85)
                push_read($urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1));
            else
                push_read($urandom_range(0, 127), $urandom_range(0, 15));
        end else if (sel < 88) begin
            // time past the last row
            push_token($urandom_range(24, 99), $urandom_range(0, 99),
                       $urandom_range(40, 129), 1'b0, 0);
        end else if (sel < 96) begin
            push_broken_token();
        end else begin
            repeat ($urandom_range(1, 3)) push_char(any_sep());
        end
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (pending_items.size() > 0 || i_valid || expected_reads.size() > 0);
    endtask

    task automatic run_phase(int idle_pct, int hold_pct);
        int target;
        send_idle_pct = idle_pct;
        stall_pct     = hold_pct;
        target        = queued + PHASE_ITEMS;
        while (queued < target) push_random_group();
        drain();
    endtask

    always @(posedge i_clk) begin : driver
        t_item nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall)
                histogram_apply('{i_mode, i_char_byte, i_read_row, i_read_col});
            if (!i_valid || !o_stall) begin
                if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt = pending_items.pop_front();
                    i_valid     <= 1'b1;
                    i_mode      <= nxt.mode;
                    i_char_byte <= nxt.chr;
                    i_read_row  <= nxt.row;
                    i_read_col  <= nxt.col;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_readout want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_reads.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected item: bin_count %0d halted %0b",
                                 o_bin_count, o_halted);
                end else begin
                    want = expected_reads.pop_front();
                    reads_checked++;
                    if (o_bin_count !== want.count || o_halted !== want.halted) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: bin_count exp %0d got %0d, halted exp %0b got %0b",
                                     want.count, o_bin_count, want.halted, o_halted);
                    end
                end
            end
            if (hold_left > 0) begin
                i_stall   <= 1'b1;
                hold_left <= hold_left - 1;
            end else if (hold_req && !hold_done) begin
                i_stall   <= 1'b1;
                hold_left <= LONG_HOLD;
                hold_done <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin : stimulus
        int hh;
        foreach (hist[i]) hist[i] = '0;
        clear_token();
        halt_seen = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // corner cells, out-of-range reads, empty token
        push_read(0, 0);
        push_read(127, 15);
        push_token(23, 59, 129, 1'b0, 0);
        push_token(0, 0, 40, 1'b0, 0);
        push_char(8'h20);
        push_read(ROWS - 1, COLS - 1);
        push_read(0, 0);
        push_read(ROWS, 0);
        push_read(0, COLS);
        drain();

        run_phase(0, 0);
        run_phase(77, 0);
        run_phase(0, 77);
        run_phase(36, 36);

        // long output hold-off while input keeps coming
        hold_req = 1'b1;
        run_phase(0, 0);

        // out-of-range rate stops all counting
        send_idle_pct = 36;
        stall_pct     = 36;
        hh = $urandom_range(0, 23);
        if ($urandom_range(0, 1))
            push_token(hh, 30, $urandom_range(130, 999), 1'b0, 0);
        else
            push_token(hh, 30, $urandom_range(0, 39), 1'b0, 0);
        push_read(hh * 4 + 2, 0);
        push_token(last_hh, last_mm, last_rate, 1'b0, 0);
        push_read((last_hh * 60 + last_mm) / 15, (last_rate - 40) / 10);
        push_char(49);
        push_char(any_sep());
        repeat (12) push_read($urandom_range(0, 127), $urandom_range(0, 15));
        drain();
        repeat (20) @(posedge i_clk);

        $display("run covered %0d counted tokens, %0d dropped tokens, %0d cell reads",
                 tokens_counted, tokens_dropped, reads_checked);
        $display("idle and stall mixes, one long output hold-off, halt state %0b", halt_seen);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> files.f
rtl/core/thrh_pkg.sv
rtl/core/thrh_parser.sv
rtl/core/thrh_ram.sv
rtl/core/thrh_update.sv
rtl/core/token_time_rate_histogram_unit.sv
rtl/core/thrh_checker.sv
tb/sv/tb_token_time_rate_histogram_unit.sv
